[rtl/crc_frame_decoder_core_defines.svh]
// Assertion macros for the crc frame decoder RTL, used by crcfd_queue.
`ifndef CRC_FRAME_DECODER_CORE_DEFINES_SVH
`define CRC_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRCFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crcfd assertion failed");

// Next-cycle implication, checked outside reset.
`define CRCFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crcfd assertion failed");

`endif

[rtl/crcfd_pkg.sv]
// Package with types, constants and the CRC byte step for the frame decoder.
`default_nettype none
package crcfd_pkg;

   localparam logic [7:0]  SYNC_BYTE   = 8'hA5;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_TOP     = 16'h8000;
   localparam int          OVERHEAD    = 10;
   localparam int          HDR_LEN     = 8;
   localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
   localparam logic [15:0] MAX_PAYLOAD = 16'd256;
   localparam int          QUEUE_DEPTH_DEF = 4;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_TOO_SHORT    = 3'd1,
      STATUS_BAD_SYNC     = 3'd2,
      STATUS_TOO_LONG     = 3'd3,
      STATUS_LEN_MISMATCH = 3'd4,
      STATUS_CRC_MISMATCH = 3'd5
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   // One queue entry: an optional forwarded byte followed by an optional verdict.
   typedef struct packed {
      logic        fwd_valid;
      logic [7:0]  payload_byte;
      logic        verdict_valid;
      status_type  status;
      logic [7:0]  version;
      logic [7:0]  msg_type;
      logic [7:0]  source_id;
      logic [7:0]  destination_id;
      logic [7:0]  header_flags;
      logic [15:0] declared_length;
      logic [15:0] received_crc;
   } entry_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[rtl/crcfd_front.sv]
// Front end: tracks frame position, captures header and CRC, builds queue entries.
`default_nettype none
module crcfd_front
   import crcfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  rx_byte,
   input  wire logic        end_of_buffer,
   output      logic        entry_valid,
   output      entry_type   entry
);

   localparam logic [16:0] POS_SYNC  = 17'd0;
   localparam logic [16:0] POS_VER   = 17'd1;
   localparam logic [16:0] POS_TYPE  = 17'd2;
   localparam logic [16:0] POS_SRC   = 17'd3;
   localparam logic [16:0] POS_DST   = 17'd4;
   localparam logic [16:0] POS_FLAGS = 17'd5;
   localparam logic [16:0] POS_LEN_H = 17'd6;
   localparam logic [16:0] POS_LEN_L = 17'd7;
   localparam logic [16:0] HDR_POS   = 17'(HDR_LEN);
   localparam logic [16:0] OVER_POS  = 17'(OVERHEAD);

   logic [16:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic        sync_ff, sync_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  source_ff, source_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] crcfield_ff, crcfield_in;

   logic [16:0] crc_pos;
   logic        fwd;
   status_type  status;

   assign crc_pos = HDR_POS + {1'b0, length_ff};

   always_comb begin
      sync_in    = sync_ff;
      version_in = version_ff;
      type_in    = type_ff;
      source_in  = source_ff;
      dest_in    = dest_ff;
      flags_in   = flags_ff;
      length_in  = length_ff;
      unique case (count_ff)
         POS_SYNC:  sync_in    = (rx_byte == SYNC_BYTE);
         POS_VER:   version_in = rx_byte;
         POS_TYPE:  type_in    = rx_byte;
         POS_SRC:   source_in  = rx_byte;
         POS_DST:   dest_in    = rx_byte;
         POS_FLAGS: flags_in   = rx_byte;
         POS_LEN_H: length_in  = {rx_byte, length_ff[7:0]};
         POS_LEN_L: length_in  = {length_ff[15:8], rx_byte};
         default:   ;
      endcase
   end

   // Header and payload feed the CRC; the two bytes at crc_pos form the trailer.
   always_comb begin
      crc_in      = crc_ff;
      crcfield_in = crcfield_ff;
      priority if (count_ff < HDR_POS || count_ff < crc_pos) begin
         crc_in = crc16_byte(crc_ff, rx_byte);
      end else if (count_ff == crc_pos) begin
         crcfield_in = {rx_byte, crcfield_ff[7:0]};
      end else if (count_ff == crc_pos + 17'd1) begin
         crcfield_in = {crcfield_ff[15:8], rx_byte};
      end else begin
         // past the trailer: count only
         crcfield_in = crcfield_ff;
      end
   end

   assign count_in = (count_ff < COUNT_MAX) ? count_ff + 17'd1 : count_ff;

   assign fwd = (count_ff >= HDR_POS) && (count_ff < crc_pos) && sync_ff &&
                (length_ff <= MAX_PAYLOAD);

   always_comb begin
      priority if (count_in < OVER_POS) begin
         status = STATUS_TOO_SHORT;
      end else if (!sync_in) begin
         status = STATUS_BAD_SYNC;
      end else if (length_in > MAX_PAYLOAD) begin
         status = STATUS_TOO_LONG;
      end else if (count_in != OVER_POS + {1'b0, length_in}) begin
         status = STATUS_LEN_MISMATCH;
      end else if (crc_in != crcfield_in) begin
         status = STATUS_CRC_MISMATCH;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      entry.fwd_valid       = fwd;
      entry.payload_byte    = rx_byte;
      entry.verdict_valid   = end_of_buffer;
      entry.status          = status;
      entry.version         = version_in;
      entry.msg_type        = type_in;
      entry.source_id       = source_in;
      entry.destination_id  = dest_in;
      entry.header_flags    = flags_in;
      entry.declared_length = length_in;
      entry.received_crc    = crcfield_in;
   end

   assign entry_valid = accept && (fwd || end_of_buffer);

   // Clear all frame state on reset and after the last byte of a buffer.
   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_buffer)) begin
         count_ff    <= '0;
         crc_ff      <= CRC_INIT;
         sync_ff     <= 1'b0;
         version_ff  <= '0;
         type_ff     <= '0;
         source_ff   <= '0;
         dest_ff     <= '0;
         flags_ff    <= '0;
         length_ff   <= '0;
         crcfield_ff <= '0;
      end else if (accept) begin
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         sync_ff     <= sync_in;
         version_ff  <= version_in;
         type_ff     <= type_in;
         source_ff   <= source_in;
         dest_ff     <= dest_in;
         flags_ff    <= flags_in;
         length_ff   <= length_in;
         crcfield_ff <= crcfield_in;
      end
   end

endmodule
`default_nettype wire

[rtl/crcfd_queue.sv]
// Short entry queue between the front end and the result emitter.
`default_nettype none
`include "crc_frame_decoder_core_defines.svh"
module crcfd_queue
   import crcfd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  wire entry_type wr_entry,
   input  wire logic      rd_en,
   output      entry_type rd_entry,
   output      logic      empty,
   output      logic      full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_CNT);
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && !empty;
   assign rd_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   `CRCFD_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= FULL_CNT)
   `CRCFD_ASSERT_NEXT(a_fill_grows, clock, reset, do_wr && !do_rd,
      count_ff == $past(count_ff) + CNT_W'(1))
   `CRCFD_ASSERT_NEXT(a_ptrs_meet, clock, reset, do_rd && !do_wr && count_ff == CNT_W'(1),
      empty && rd_ptr_ff == wr_ptr_ff)

endmodule
`default_nettype wire

[rtl/crcfd_back.sv]
// Back end: turns each queue entry into a forwarded-byte result, a verdict, or both.
`default_nettype none
module crcfd_back
   import crcfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire entry_type   head,
   input  wire logic        head_empty,
   output      logic        head_rd,
   input  wire logic        rsp_pop,
   output      logic        rsp_empty,
   output      logic        rsp_kind,
   output      logic [7:0]  rsp_payload_byte,
   output      logic [2:0]  rsp_status,
   output      logic [7:0]  rsp_version,
   output      logic [7:0]  rsp_msg_type,
   output      logic [7:0]  rsp_source_id,
   output      logic [7:0]  rsp_destination_id,
   output      logic [7:0]  rsp_header_flags,
   output      logic [15:0] rsp_declared_length,
   output      logic [15:0] rsp_received_crc
);

   // Set once the byte of a two-result entry has gone out.
   logic phase_ff, phase_in;
   logic show_byte, take;

   assign show_byte = head.fwd_valid && !phase_ff;
   assign take      = rsp_pop && !head_empty;
   assign rsp_empty = head_empty;
   assign head_rd   = take && !(show_byte && head.verdict_valid);

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         phase_in = show_byte && head.verdict_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      if (show_byte) begin
         rsp_kind            = KIND_PAYLOAD;
         rsp_payload_byte    = head.payload_byte;
         rsp_status          = STATUS_OK;
         rsp_version         = '0;
         rsp_msg_type        = '0;
         rsp_source_id       = '0;
         rsp_destination_id  = '0;
         rsp_header_flags    = '0;
         rsp_declared_length = '0;
         rsp_received_crc    = '0;
      end else begin
         rsp_kind            = KIND_VERDICT;
         rsp_payload_byte    = '0;
         rsp_status          = head.status;
         rsp_version         = head.version;
         rsp_msg_type        = head.msg_type;
         rsp_source_id       = head.source_id;
         rsp_destination_id  = head.destination_id;
         rsp_header_flags    = head.header_flags;
         rsp_declared_length = head.declared_length;
         rsp_received_crc    = head.received_crc;
      end
   end

endmodule
`default_nettype wire

[rtl/crc_frame_decoder_core.sv]
// Top level of the CRC-16 framed packet decoder.
// Takes one received byte per cycle (sync 0xA5, five header bytes, 16-bit big-endian
// length, payload, 16-bit big-endian CRC-16/CCITT-FALSE trailer; end_of_buffer on the last
// byte) and returns payload bytes as they arrive plus one verdict per buffer. The front
// end updates the CRC and header state in the same cycle a byte is accepted, so input runs
// at one byte per cycle while the entry queue (QUEUE_DEPTH entries) has room; req_full
// follows the queue and holds every byte, result-bearing or not, while it is full. A
// result is on the result ports once its queue entry, written when its byte is accepted,
// reaches the queue head. Each entry yields one result per pop; the last entry of a
// buffer ending in payload yields the byte, then the verdict. No clearing pass after reset.
`default_nettype none
module crc_frame_decoder_core
   import crcfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output      logic        req_full,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_end_of_buffer,
   output      logic        rsp_empty,
   input  wire logic        rsp_pop,
   output      logic        rsp_kind,
   output      logic [7:0]  rsp_payload_byte,
   output      logic [2:0]  rsp_status,
   output      logic [7:0]  rsp_version,
   output      logic [7:0]  rsp_msg_type,
   output      logic [7:0]  rsp_source_id,
   output      logic [7:0]  rsp_destination_id,
   output      logic [7:0]  rsp_header_flags,
   output      logic [15:0] rsp_declared_length,
   output      logic [15:0] rsp_received_crc
);

   logic      accept;
   logic      entry_valid;
   entry_type entry;
   entry_type head;
   logic      head_empty;
   logic      head_rd;

   assign accept = req_push && !req_full;

   crcfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_rx_byte),
      .end_of_buffer (req_end_of_buffer),
      .entry_valid   (entry_valid),
      .entry         (entry)
   );

   crcfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_valid),
      .wr_entry (entry),
      .rd_en    (head_rd),
      .rd_entry (head),
      .empty    (head_empty),
      .full     (req_full)
   );

   crcfd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .head_empty          (head_empty),
      .head_rd             (head_rd),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_kind            (rsp_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_status          (rsp_status),
      .rsp_version         (rsp_version),
      .rsp_msg_type        (rsp_msg_type),
      .rsp_source_id       (rsp_source_id),
      .rsp_destination_id  (rsp_destination_id),
      .rsp_header_flags    (rsp_header_flags),
      .rsp_declared_length (rsp_declared_length),
      .rsp_received_crc    (rsp_received_crc)
   );

endmodule
`default_nettype wire

[tb/sv/tb_crc_frame_decoder_core.sv]
// Self-checking testbench for the CRC-16 framed packet decoder core.
`timescale 1ns / 1ps
module tb_crc_frame_decoder_core
   import crcfd_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned DRAIN_CYCLES = 16;

   typedef struct {
      kind_type    kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [7:0]  version;
      logic [7:0]  msg_type;
      logic [7:0]  source_id;
      logic [7:0]  destination_id;
      logic [7:0]  header_flags;
      logic [15:0] declared_length;
      logic [15:0] received_crc;
   } deframer_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_version;
   logic [7:0]  rsp_msg_type;
   logic [7:0]  rsp_source_id;
   logic [7:0]  rsp_destination_id;
   logic [7:0]  rsp_header_flags;
   logic [15:0] rsp_declared_length;
   logic [15:0] rsp_received_crc;

   crc_frame_decoder_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_rx_byte         (req_rx_byte),
      .req_end_of_buffer   (req_end_of_buffer),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_kind            (rsp_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_status          (rsp_status),
      .rsp_version         (rsp_version),
      .rsp_msg_type        (rsp_msg_type),
      .rsp_source_id       (rsp_source_id),
      .rsp_destination_id  (rsp_destination_id),
      .rsp_header_flags    (rsp_header_flags),
      .rsp_declared_length (rsp_declared_length),
      .rsp_received_crc    (rsp_received_crc)
   );

   always #6 clock = ~clock;

   // Deframer state mirrored by the testbench
   logic [16:0] frame_pos = '0;
   logic [15:0] crc_acc = CRC_INIT;
   logic        sync_ok = 1'b0;
   logic [7:0]  hdr_version = '0;
   logic [7:0]  hdr_type = '0;
   logic [7:0]  hdr_source = '0;
   logic [7:0]  hdr_destination = '0;
   logic [7:0]  hdr_flags = '0;
   logic [15:0] len_field = '0;
   logic [15:0] trailer_crc = '0;

   deframer_result_type pending_results[$];
   logic [7:0]          frame_bytes[$];
   int unsigned         error_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;

   function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic void clear_decoder();
      frame_pos = '0;
      crc_acc = CRC_INIT;
      sync_ok = 1'b0;
      hdr_version = '0;
      hdr_type = '0;
      hdr_source = '0;
      hdr_destination = '0;
      hdr_flags = '0;
      len_field = '0;
      trailer_crc = '0;
   endfunction

   // Advance the mirrored deframer by one byte; queue the payload byte and verdict it yields.
   function automatic void decode_byte(input logic [7:0] b, input logic eob);
      logic [16:0]         pos;
      int unsigned         trailer_pos;
      deframer_result_type r;
      pos = frame_pos;
      case (pos)
         17'd0: sync_ok = (b == SYNC_BYTE);
         17'd1: hdr_version = b;
         17'd2: hdr_type = b;
         17'd3: hdr_source = b;
         17'd4: hdr_destination = b;
         17'd5: hdr_flags = b;
         17'd6: len_field[15:8] = b;
         17'd7: len_field[7:0] = b;
         default: ;
      endcase
      trailer_pos = HDR_LEN + len_field;
      if (pos < HDR_LEN || pos < trailer_pos) begin
         crc_acc = crc_ccitt_byte(crc_acc, b);
      end else if (pos == trailer_pos) begin
         trailer_crc[15:8] = b;
      end else if (pos == trailer_pos + 1) begin
         trailer_crc[7:0] = b;
      end
      r.kind = KIND_PAYLOAD;
      r.payload_byte = 8'h00;
      r.status = STATUS_OK;
      r.version = '0;
      r.msg_type = '0;
      r.source_id = '0;
      r.destination_id = '0;
      r.header_flags = '0;
      r.declared_length = '0;
      r.received_crc = '0;
      if (pos >= HDR_LEN && pos < trailer_pos && sync_ok && len_field <= MAX_PAYLOAD) begin
         r.payload_byte = b;
         pending_results.push_back(r);
      end
      // hold at the top once the counter saturates
      if (frame_pos != COUNT_MAX) frame_pos = frame_pos + 1'b1;
      if (eob) begin
         r.kind = KIND_VERDICT;
         r.payload_byte = 8'h00;
         if (frame_pos < OVERHEAD) r.status = STATUS_TOO_SHORT;
         else if (!sync_ok) r.status = STATUS_BAD_SYNC;
         else if (len_field > MAX_PAYLOAD) r.status = STATUS_TOO_LONG;
         else if (int'(frame_pos) != OVERHEAD + int'(len_field)) r.status = STATUS_LEN_MISMATCH;
         else if (crc_acc != trailer_crc) r.status = STATUS_CRC_MISMATCH;
         else r.status = STATUS_OK;
         r.version = hdr_version;
         r.msg_type = hdr_type;
         r.source_id = hdr_source;
         r.destination_id = hdr_destination;
         r.header_flags = hdr_flags;
         r.declared_length = len_field;
         r.received_crc = trailer_crc;
         pending_results.push_back(r);
         clear_decoder();
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_result();
      deframer_result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                  $time, rsp_kind, rsp_status);
         error_count++;
         return;
      end
      want = pending_results.pop_front();
      check_field("kind", want.kind, rsp_kind);
      check_field("payload_byte", want.payload_byte, rsp_payload_byte);
      check_field("status", want.status, rsp_status);
      check_field("version", want.version, rsp_version);
      check_field("msg_type", want.msg_type, rsp_msg_type);
      check_field("source_id", want.source_id, rsp_source_id);
      check_field("destination_id", want.destination_id, rsp_destination_id);
      check_field("header_flags", want.header_flags, rsp_header_flags);
      check_field("declared_length", want.declared_length, rsp_declared_length);
      check_field("received_crc", want.received_crc, rsp_received_crc);
   endfunction

   // Predict on each accepted byte before checking the result transaction of the same edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
      end else begin
         if (req_push && !req_full) decode_byte(req_rx_byte, req_end_of_buffer);
         if (rsp_pop && !rsp_empty) check_result();
      end
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("crc_frame_decoder_core verification failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eob);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      req_end_of_buffer <= eob;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_buffer();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // Build sync, header, length, payload and trailer; crc_flip corrupts the trailer.
   task automatic make_frame(input logic [7:0] sync_b, input logic [39:0] hdr,
                             input logic [15:0] len_v, input int unsigned n_payload,
                             input logic [15:0] crc_flip);
      logic [15:0] crc;
      frame_bytes.delete();
      frame_bytes.push_back(sync_b);
      for (int i = 4; i >= 0; i--) frame_bytes.push_back(hdr[i*8 +: 8]);
      frame_bytes.push_back(len_v[15:8]);
      frame_bytes.push_back(len_v[7:0]);
      repeat (n_payload) frame_bytes.push_back(8'($urandom_range(255)));
      crc = CRC_INIT;
      foreach (frame_bytes[i]) crc = crc_ccitt_byte(crc, frame_bytes[i]);
      crc ^= crc_flip;
      frame_bytes.push_back(crc[15:8]);
      frame_bytes.push_back(crc[7:0]);
   endtask

   function automatic logic [39:0] random_header();
      logic [39:0] h;
      h[31:0] = $urandom();
      h[39:32] = 8'($urandom_range(255));
      return h;
   endfunction

   function automatic logic [15:0] random_length();
      case ($urandom_range(39))
         0: return MAX_PAYLOAD;
         1: return MAX_PAYLOAD - 16'd1;
         default: return 16'($urandom_range(12));
      endcase
   endfunction

   task automatic test_frame_edges();
      // lone byte: too short, nothing captured
      frame_bytes.delete();
      frame_bytes.push_back(8'hFF);
      send_buffer();
      // minimal good frame with alternating header extremes
      make_frame(SYNC_BYTE, 40'h00FF00FF00, 16'd0, 0, 16'h0000);
      send_buffer();
      // end the buffer on a payload byte: forward it, then the verdict
      make_frame(SYNC_BYTE, 40'hFFFFFFFFFF, 16'd1, 1, 16'h0000);
      void'(frame_bytes.pop_back());
      void'(frame_bytes.pop_back());
      frame_bytes[8] = 8'hFF;
      send_buffer();
   endtask

   task automatic test_random_frames(input int unsigned n_items);
      int unsigned sent;
      int unsigned pick;
      int unsigned keep;
      logic [7:0]  sync_b;
      logic [15:0] len_v;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         len_v = random_length();
         if (pick < 55) begin
            make_frame(SYNC_BYTE, random_header(), len_v, len_v, 16'h0000);
         end else if (pick < 63) begin
            make_frame(SYNC_BYTE, random_header(), len_v, len_v,
                       16'($urandom_range(1, 16'hFFFF)));
         end else if (pick < 70) begin
            sync_b = 8'($urandom_range(255));
            if (sync_b == SYNC_BYTE) sync_b ^= 8'h01;
            make_frame(sync_b, random_header(), len_v, len_v, 16'h0000);
         end else if (pick < 76) begin
            // oversized length field: send only a short tail
            len_v = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(257, 16'hFFFF));
            make_frame(SYNC_BYTE, random_header(), len_v, $urandom_range(12), 16'h0000);
         end else if (pick < 84) begin
            // trailing bytes past the CRC field
            make_frame(SYNC_BYTE, random_header(), len_v, len_v, 16'h0000);
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(255)));
         end else if (pick < 92) begin
            make_frame(SYNC_BYTE, random_header(), len_v, len_v, 16'h0000);
            keep = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
         end else begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 14)) frame_bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(1) == 0) frame_bytes[0] = SYNC_BYTE;
         end
         send_buffer();
         sent += frame_bytes.size();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 57;
      test_frame_edges();
      test_random_frames(250);
      send_idle_pct = 57;
      recv_idle_pct = 24;
      test_random_frames(250);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(250);
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("crc_frame_decoder_core verification clean");
      end else begin
         $display("crc_frame_decoder_core verification failed");
      end
      $finish;
   end

endmodule
